@@ rtl/vfp_pkg.sv @@
// ----------------------------------------------------------------------------
// vfp_pkg
// shared types and constants of the video frame packetizer
// ----------------------------------------------------------------------------
`default_nettype none

package vfp_pkg;

   localparam int MAX_DATAGRAM_BYTES = 1500;
   localparam int HEADER_BYTES       = 60;
   localparam int PAY_W              = 11;
   localparam int PAYLOAD_LIMIT      = MAX_DATAGRAM_BYTES - HEADER_BYTES;
   localparam int PAYLOAD_RESET      = 1400;

   // request tdata: byte 8, timestamp 64, frame number 32, keyframe 1,
   // header length 32, data length 32, padded to whole bytes
   localparam int REQ_W = 176;
   // response tdata: 296 bits, no padding needed
   localparam int RSP_W = 296;
   // response tuser: flags 4, error 2
   localparam int RSP_USER_W = 6;

   localparam int DIV_W = 32;

   typedef enum logic {
      OP_DESC = 1'b0,
      OP_BYTE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_EMPTY     = 2'd1,
      ERR_TOO_LARGE = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic    desc_clear;
      logic    desc_start;
      logic    byte_step;
      logic    frame_commit;
      logic    err_load;
      err_type err_code;
   } cmd_type;

   typedef struct packed {
      logic desc_empty;
      logic desc_oversize;
      logic div_done;
      logic div_too_many;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/vfp_divider.sv @@
// ----------------------------------------------------------------------------
// vfp_divider
// restoring divider, one quotient bit per cycle, for the packet count
// ----------------------------------------------------------------------------
`default_nettype none

module vfp_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [vfp_pkg::DIV_W-1:0]  dividend,
   input  wire logic [vfp_pkg::PAY_W-1:0]  divisor,
   output logic                            done,
   output logic [vfp_pkg::DIV_W-1:0]       quotient,
   output logic                            rem_nonzero
);
   import vfp_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0] dvd_ff, dvd_in;
   logic [PAY_W-1:0] rem_ff, rem_in;
   logic [PAY_W-1:0] div_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [PAY_W:0]   trial;
   logic [PAY_W:0]   diff;
   logic             ge;

   assign trial  = {rem_ff, dvd_ff[DIV_W-1]};
   assign diff   = trial - {1'b0, div_ff};
   assign ge     = trial >= {1'b0, div_ff};
   assign rem_in = ge ? diff[PAY_W-1:0] : trial[PAY_W-1:0];
   assign dvd_in = {dvd_ff[DIV_W-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign done        = done_ff;
   assign quotient    = dvd_ff;
   assign rem_nonzero = rem_ff != '0;

endmodule

`default_nettype wire

@@ rtl/vfp_datapath.sv @@
// ----------------------------------------------------------------------------
// vfp_datapath
// frame metadata, packet counters, sequence numbers and the response register
// ----------------------------------------------------------------------------
`default_nettype none

module vfp_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [vfp_pkg::REQ_W-1:0]      req_tdata,
   input  wire vfp_pkg::cmd_type               cmd,
   output vfp_pkg::status_type                 status,
   input  wire logic                           csr_valid,
   input  wire logic [vfp_pkg::PAY_W-1:0]      csr_data,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [vfp_pkg::RSP_W-1:0]           rsp_tdata,
   output logic                                rsp_tlast,
   output logic [vfp_pkg::RSP_USER_W-1:0]      rsp_tuser
);
   import vfp_pkg::*;

   // request fields
   logic [7:0]  in_byte;
   logic [63:0] in_time;
   logic [31:0] in_tag;
   logic        in_key;
   logic [31:0] in_hlen;
   logic [31:0] in_dlen;
   logic [32:0] total_sum;

   assign in_byte   = req_tdata[7:0];
   assign in_time   = req_tdata[71:8];
   assign in_tag    = req_tdata[103:72];
   assign in_key    = req_tdata[104];
   assign in_hlen   = req_tdata[136:105];
   assign in_dlen   = req_tdata[168:137];
   assign total_sum = {1'b0, in_hlen} + {1'b0, in_dlen};

   logic [PAY_W-1:0] payload_ff;
   logic [63:0]      time_ff;
   logic [31:0]      tag_ff;
   logic [31:0]      flen_ff;
   logic [31:0]      clen_ff;
   logic [PAY_W-1:0] pay_ff;
   logic [1:0]       flag_base_ff;
   logic [15:0]      count_ff;
   logic [15:0]      idx_ff;
   logic [31:0]      bpos_ff;
   logic [PAY_W-1:0] pip_ff;
   logic [63:0]      cur_seq_ff;
   logic [63:0]      next_seq_ff;
   logic             active_ff;

   logic                rsp_valid_ff;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   // divider
   logic             div_done;
   logic [DIV_W-1:0] div_q;
   logic             div_rem_nz;
   logic             too_many;
   logic [15:0]      count_calc;

   vfp_divider u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.desc_start),
      .dividend    (total_sum[DIV_W-1:0]),
      .divisor     (payload_ff),
      .done        (div_done),
      .quotient    (div_q),
      .rem_nonzero (div_rem_nz)
   );

   assign too_many   = (div_q[DIV_W-1:16] != '0) || ((div_q[15:0] == 16'hFFFF) && div_rem_nz);
   assign count_calc = div_q[15:0] + {15'd0, div_rem_nz};

   // per-byte packet logic
   logic        emit;
   logic        frame_end;
   logic        pkt_end;
   logic [3:0]  flags;
   logic [31:0] offset;

   assign emit      = cmd.byte_step && active_ff;
   assign frame_end = ({1'b0, bpos_ff} + 33'd1) >= {1'b0, flen_ff};
   assign pkt_end   = frame_end || (({1'b0, pip_ff} + 12'd1) >= {1'b0, pay_ff});
   assign flags     = {({1'b0, idx_ff} + 17'd1) == {1'b0, count_ff},
                       idx_ff == 16'd0, flag_base_ff};
   assign offset    = bpos_ff - {{(32-PAY_W){1'b0}}, pip_ff};

   always_comb begin
      rsp_data_in = '0;
      rsp_last_in = 1'b0;
      rsp_user_in = {ERR_NONE, 4'd0};
      if (cmd.err_load) begin
         rsp_user_in = {cmd.err_code, 4'd0};
      end else begin
         rsp_data_in = {time_ff, tag_ff, clen_ff, flen_ff, offset, count_ff, idx_ff,
                        cur_seq_ff, in_byte};
         rsp_last_in = pkt_end;
         rsp_user_in = {ERR_NONE, flags};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         payload_ff   <= PAY_W'(PAYLOAD_RESET);
         active_ff    <= 1'b0;
         cur_seq_ff   <= '0;
         next_seq_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // saturate register writes into the legal payload range
         if (csr_valid) begin
            if (csr_data == '0) begin
               payload_ff <= PAY_W'(1);
            end else if (csr_data > PAY_W'(PAYLOAD_LIMIT)) begin
               payload_ff <= PAY_W'(PAYLOAD_LIMIT);
            end else begin
               payload_ff <= csr_data;
            end
         end

         if (cmd.desc_clear) begin
            active_ff <= 1'b0;
         end else if (cmd.frame_commit) begin
            active_ff   <= 1'b1;
            cur_seq_ff  <= next_seq_ff;
            next_seq_ff <= next_seq_ff + 64'd1;
         end else if (emit) begin
            if (frame_end) begin
               active_ff <= 1'b0;
            end else if (pkt_end) begin
               cur_seq_ff  <= next_seq_ff;
               next_seq_ff <= next_seq_ff + 64'd1;
            end
         end

         if (emit || cmd.err_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.desc_start) begin
         time_ff      <= in_time;
         tag_ff       <= in_tag;
         flen_ff      <= total_sum[31:0];
         clen_ff      <= in_hlen;
         pay_ff       <= payload_ff;
         flag_base_ff <= {in_hlen != '0, in_key};
      end
      if (cmd.frame_commit) begin
         count_ff <= count_calc;
         idx_ff   <= '0;
         bpos_ff  <= '0;
         pip_ff   <= '0;
      end else if (emit) begin
         bpos_ff <= bpos_ff + 32'd1;
         if (!frame_end && pkt_end) begin
            pip_ff <= '0;
            idx_ff <= idx_ff + 16'd1;
         end else begin
            pip_ff <= pip_ff + 1'b1;
         end
      end
      if (emit || cmd.err_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign status.desc_empty    = in_dlen == '0;
   assign status.desc_oversize = total_sum[32];
   assign status.div_done      = div_done;
   assign status.div_too_many  = too_many;
   assign status.out_free      = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

@@ rtl/vfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// vfp_ctrl
// controller: request acceptance, descriptor checks and packet count wait
// ----------------------------------------------------------------------------
`default_nettype none

module vfp_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic                req_tuser,
   input  wire vfp_pkg::status_type status,
   output vfp_pkg::cmd_type         cmd
);
   import vfp_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser == OP_DESC && !status.desc_empty &&
                !status.desc_oversize) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.div_too_many || status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      cmd.err_code = ERR_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = status.out_free;
            if (accept) begin
               if (req_tuser == OP_DESC) begin
                  cmd.desc_clear = 1'b1;
                  priority if (status.desc_empty) begin
                     cmd.err_load = 1'b1;
                     cmd.err_code = ERR_EMPTY;
                  end else if (status.desc_oversize) begin
                     cmd.err_load = 1'b1;
                     cmd.err_code = ERR_TOO_LARGE;
                  end else begin
                     cmd.desc_start = 1'b1;
                  end
               end else begin
                  cmd.byte_step = 1'b1;
               end
            end
         end
         ST_DIVIDE: begin
         end
         ST_FINISH: begin
            if (!status.div_too_many) begin
               cmd.frame_commit = 1'b1;
            end else if (status.out_free) begin
               cmd.err_load = 1'b1;
               cmd.err_code = ERR_TOO_LARGE;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/video_frame_packetizer.sv @@
// frame bytes: one per cycle while the response register is free, result in
//   the cycle after acceptance; descriptor: request side stalled for 32
//   divider steps (packet count), the done check and the commit or error load;
//   a too-many-packets error also waits until the response register is free
// empty data or a length sum over 32 bits: error in the cycle after acceptance
// reset: synchronous, active high; no frame active, sequence at zero, size 1400
// ----------------------------------------------------------------------------
// video_frame_packetizer
// splits each frame into packets of the configured payload size and tags
// every byte with its packet's header fields
// ----------------------------------------------------------------------------
`default_nettype none

module video_frame_packetizer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // byte_value, timestamp, frame_number, keyframe, header_length,
   // data_length, zero padding
   input  wire logic [vfp_pkg::REQ_W-1:0]        req_tdata,
   // op
   input  wire logic                             req_tuser,
   // response channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // out_byte, sequence_res, packet_index, packet_total, packet_offset,
   // frame_length, codec_length, frame_tag, frame_time
   output logic [vfp_pkg::RSP_W-1:0]             rsp_tdata,
   // packet_last
   output logic                                  rsp_tlast,
   // flags, error
   output logic [vfp_pkg::RSP_USER_W-1:0]        rsp_tuser,
   // payload size register write
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [vfp_pkg::PAY_W-1:0]        csr_data
);
   import vfp_pkg::*;

   cmd_type    cmd;
   status_type status;

   // the register is always writable; the new size applies from the next
   // descriptor, a frame in progress keeps the size latched at its start
   assign csr_ready = 1'b1;

   // controller: accepts requests, sorts descriptors and waits on the divider
   vfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: metadata, counters, sequence numbers and output register
   vfp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ bench/video_frame_packetizer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_frame_packetizer_test
// self-checking bench for the frame packetizer: a directed table walks the
// error descriptors, the length and payload extremes and the mid-frame cases,
// then random frames (mostly complete, some cut short, some oversized) run
// under random payload sizes; every tagged byte is checked field by field
// against an in-bench packetizer model
// ----------------------------------------------------------------------------

module video_frame_packetizer_test;

   import vfp_pkg::*;

   localparam int ITEM_GOAL    = 1850;
   localparam int QUIET_ITEMS  = 250;   // closing stretch with no idling
   localparam int DRAIN_CYCLES = 48;    // outlasts a descriptor's hold on the block
   localparam int LONG_HOLD    = 500;   // receiver hold-off to fill the block
   localparam int NUM_ROWS     = 28;

   // request tdata from the lowest bit up: byte_value, timestamp,
   // frame_number, keyframe, header_length, data_length, zero padding
   typedef struct packed {
      logic [6:0]  pad;
      logic [31:0] data_length;
      logic [31:0] header_length;
      logic        keyframe;
      logic [31:0] frame_number;
      logic [63:0] stamp_ns;
      logic [7:0]  byte_value;
   } req_word_type;

   // response tdata from the lowest bit up: out_byte, sequence, packet_index,
   // packet_total, packet_offset, frame_length, codec_length, frame_tag,
   // frame_time
   typedef struct packed {
      logic [63:0] frame_time;
      logic [31:0] frame_tag;
      logic [31:0] codec_length;
      logic [31:0] frame_length;
      logic [31:0] packet_offset;
      logic [15:0] packet_total;
      logic [15:0] packet_index;
      logic [63:0] sequence_res;
      logic [7:0]  out_byte;
   } rsp_word_type;

   // one tagged byte as it should leave the block
   typedef struct packed {
      rsp_word_type data;
      logic         last;
      logic [3:0]   flags;
      err_type      err;
   } pkt_byte_type;

   typedef enum logic { ROW_ITEM, ROW_CSR } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      op_type            op;
      logic [7:0]        bval;
      logic [63:0]       ts;
      logic [31:0]       fnum;
      logic              kf;
      logic [31:0]       hlen;
      logic [31:0]       dlen;
      logic [PAY_W-1:0]  csr_value;
      logic              typed;
      err_type           terr;
   } stim_row_type;

   // ------------------------------------------------------------------------
   // block signals, all inputs known from time zero
   // ------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [PAY_W-1:0]      csr_data = '0;

   video_frame_packetizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // bench-side packetizer state
   // ------------------------------------------------------------------------
   logic [PAY_W-1:0] payload_cfg = PAYLOAD_RESET[PAY_W-1:0];
   logic [63:0]      seq_next   = '0;
   logic [63:0]      seq_cur    = '0;
   logic             in_frame   = 1'b0;
   logic [31:0]      frame_pos  = '0;
   logic [PAY_W-1:0] pkt_pos    = '0;
   logic [15:0]      pkt_idx    = '0;
   logic [15:0]      pkt_cnt    = '0;
   logic [63:0]      lat_time   = '0;
   logic [31:0]      lat_tag    = '0;
   logic [31:0]      lat_flen   = '0;
   logic [31:0]      lat_clen   = '0;
   logic [PAY_W-1:0] lat_pay    = '0;
   logic [1:0]       flag_base  = '0;

   pkt_byte_type tagged_bytes_due[$];   // tagged bytes still owed by the block
   int      items_sent = 0;
   int      mismatches = 0;
   bit      quiet = 1'b0;          // set for the closing stretch

   // works out the tagged byte (if any) for one accepted transaction and
   // steps the bench state; returns 1 when the block owes a result
   function automatic bit packetize(input op_type op, input req_word_type f,
                                    output pkt_byte_type r);
      logic [63:0] total;
      logic [63:0] pay;
      logic [63:0] count;
      bit          frame_end;
      bit          pkt_end;
      r = '0;
      if (op == OP_DESC) begin
         total = {32'd0, f.header_length} + {32'd0, f.data_length};
         pay   = {{(64-PAY_W){1'b0}}, payload_cfg};
         in_frame = 1'b0;   // any frame in progress is dropped
         if (f.data_length == 32'd0) begin
            r.err = ERR_EMPTY;
            return 1'b1;
         end
         if (total > 64'hFFFF_FFFF) begin
            r.err = ERR_TOO_LARGE;
            return 1'b1;
         end
         count = (total + pay - 64'd1) / pay;
         if (count > 64'd65535) begin
            r.err = ERR_TOO_LARGE;
            return 1'b1;
         end
         // latch the frame, first packet takes the next sequence value
         lat_time   = f.stamp_ns;
         lat_tag    = f.frame_number;
         lat_flen   = total[31:0];
         lat_clen   = f.header_length;
         lat_pay    = payload_cfg;
         flag_base  = {f.header_length != 32'd0, f.keyframe};
         pkt_cnt    = count[15:0];
         pkt_idx    = '0;
         frame_pos  = '0;
         pkt_pos    = '0;
         seq_cur    = seq_next;
         seq_next   = seq_next + 64'd1;
         in_frame   = 1'b1;
         return 1'b0;
      end
      if (!in_frame)
         return 1'b0;   // stray byte, ignored
      frame_end = ({32'd0, frame_pos} + 64'd1) >= {32'd0, lat_flen};
      pkt_end   = frame_end ||
                  (({{(64-PAY_W){1'b0}}, pkt_pos} + 64'd1) >=
                   {{(64-PAY_W){1'b0}}, lat_pay});
      r.data.out_byte      = f.byte_value;
      r.last               = pkt_end;
      r.data.sequence_res  = seq_cur;
      r.data.packet_index  = pkt_idx;
      r.data.packet_total  = pkt_cnt;
      r.data.packet_offset = frame_pos - {{(32-PAY_W){1'b0}}, pkt_pos};
      r.data.frame_length  = lat_flen;
      r.data.codec_length  = lat_clen;
      r.data.frame_tag     = lat_tag;
      r.data.frame_time    = lat_time;
      r.flags = {2'b00, flag_base};
      if (pkt_idx == 16'd0)
         r.flags[2] = 1'b1;
      if ({1'b0, pkt_idx} + 17'd1 == {1'b0, pkt_cnt})
         r.flags[3] = 1'b1;
      r.err = ERR_NONE;
      frame_pos = frame_pos + 32'd1;
      pkt_pos   = pkt_pos + 1'b1;
      if (frame_end) begin
         in_frame = 1'b0;
      end else if (pkt_end) begin
         pkt_pos  = '0;
         pkt_idx  = pkt_idx + 16'd1;
         seq_cur  = seq_next;
         seq_next = seq_next + 64'd1;
      end
      return 1'b1;
   endfunction

   function automatic req_word_type desc_word(input logic [63:0] ts,
                                              input logic [31:0] fnum,
                                              input logic kf, input logic [31:0] hlen,
                                              input logic [31:0] dlen);
      req_word_type w;
      w = '0;
      w.byte_value      = 8'($urandom);   // don't-care on a descriptor
      w.stamp_ns        = ts;
      w.frame_number    = fnum;
      w.keyframe        = kf;
      w.header_length   = hlen;
      w.data_length     = dlen;
      return w;
   endfunction

   // frame byte with random noise in the descriptor-only fields
   function automatic req_word_type byte_word(input logic [7:0] v);
      req_word_type w;
      w = '0;
      w.byte_value      = v;
      w.stamp_ns        = {$urandom, $urandom};
      w.frame_number    = $urandom;
      w.keyframe        = 1'($urandom);
      w.header_length   = $urandom;
      w.data_length     = $urandom;
      return w;
   endfunction

   function automatic stim_row_type row_desc(input logic [63:0] ts, input logic [31:0] fnum,
                                             input logic kf, input logic [31:0] hlen,
                                             input logic [31:0] dlen, input logic typed,
                                             input err_type terr);
      stim_row_type s;
      s = '0;
      s.kind = ROW_ITEM;
      s.op   = OP_DESC;
      s.ts   = ts;
      s.fnum = fnum;
      s.kf   = kf;
      s.hlen = hlen;
      s.dlen = dlen;
      s.typed = typed;
      s.terr  = terr;
      return s;
   endfunction

   function automatic stim_row_type row_byte(input logic [7:0] v);
      stim_row_type s;
      s = '0;
      s.kind = ROW_ITEM;
      s.op   = OP_BYTE;
      s.bval = v;
      return s;
   endfunction

   function automatic stim_row_type row_csr(input logic [PAY_W-1:0] v);
      stim_row_type s;
      s = '0;
      s.kind      = ROW_CSR;
      s.csr_value = v;
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // request side: drive at the falling edge, accept at the rising edge
   // ------------------------------------------------------------------------
   task automatic offer(input op_type op, input req_word_type w, input logic typed,
                        input err_type terr);
      pkt_byte_type r;
      bit           made;
      req_tuser  <= op;
      req_tdata  <= w;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      made = packetize(op, w, r);
      // error codes of directed rows are typed in rather than predicted
      if (typed) begin
         r     = '0;
         r.err = terr;
         made  = 1'b1;
      end
      if (made)
         tagged_bytes_due = {tagged_bytes_due, r};
      items_sent++;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
   endtask

   // block idle: nothing owed and any descriptor division finished
   task automatic wait_drained();
      if (req_tvalid)
         req_tvalid <= 1'b0;
      while (tagged_bytes_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_payload_size(input logic [PAY_W-1:0] v);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      // writes saturate into the legal payload range
      if (v == '0)
         payload_cfg = PAY_W'(1);
      else if (v > PAYLOAD_LIMIT)
         payload_cfg = PAYLOAD_LIMIT[PAY_W-1:0];
      else
         payload_cfg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // stimulus: directed table first, then random frames in phases
   // ------------------------------------------------------------------------
   stim_row_type script [NUM_ROWS];

   initial begin : stimulus
      int          n;
      int unsigned pay;
      int unsigned total;
      int unsigned hlen;
      int unsigned nsend;
      int unsigned kind;
      int unsigned sub;
      logic [PAY_W-1:0] v;

      // after reset the payload is 1400: stray byte, errors, one short frame
      script[0]  = row_byte(8'h3C);
      script[1]  = row_desc(64'd0, 32'd0, 1'b0, 32'h0000_0010, 32'd0, 1'b1, ERR_EMPTY);
      script[2]  = row_desc('1, '1, 1'b1, 32'hFFFF_FFFF, 32'd1, 1'b1, ERR_TOO_LARGE);
      script[3]  = row_desc(64'd0, 32'd0, 1'b0, 32'd0, 32'hFFFF_FFFF, 1'b1, ERR_TOO_LARGE);
      script[4]  = row_desc('1, '1, 1'b1, 32'd2, 32'd3, 1'b0, ERR_NONE);
      script[5]  = row_byte(8'h00);
      script[6]  = row_byte(8'hFF);
      script[7]  = row_byte(8'hA5);
      script[8]  = row_byte(8'h5A);
      script[9]  = row_byte(8'h01);
      // zero saturates up to one byte per packet
      script[10] = row_csr('0);
      script[11] = row_desc(64'h0123_4567_89AB_CDEF, 32'h8000_0000, 1'b0, 32'd0, 32'd2,
                            1'b0, ERR_NONE);
      script[12] = row_byte(8'h80);
      script[13] = row_byte(8'h7F);
      // one packet too many, then exactly the packet limit
      script[14] = row_desc(64'd5, 32'd6, 1'b0, 32'd0, 32'd65536, 1'b1, ERR_TOO_LARGE);
      script[15] = row_desc(64'd7, 32'd8, 1'b1, 32'd65534, 32'd1, 1'b0, ERR_NONE);
      script[16] = row_byte(8'h11);
      // all-ones saturates down; the frame in flight keeps its latched size
      script[17] = row_csr('1);
      script[18] = row_byte(8'h22);
      // new descriptor abandons the frame in progress
      script[19] = row_desc(64'h8000_0000_0000_0000, 32'h7FFF_FFFF, 1'b0, 32'd1, 32'd2,
                            1'b0, ERR_NONE);
      script[20] = row_csr(11'd2);
      script[21] = row_byte(8'hC3);
      script[22] = row_byte(8'h3C);
      script[23] = row_byte(8'h96);
      script[24] = row_desc(64'd9, 32'd10, 1'b1, 32'd0, 32'd3, 1'b0, ERR_NONE);
      script[25] = row_byte(8'h69);
      script[26] = row_byte(8'hF0);
      script[27] = row_byte(8'h0F);

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (n = 0; n < NUM_ROWS; n++) begin
         if (script[n].kind == ROW_CSR) begin
            wait_drained();
            write_payload_size(script[n].csr_value);
         end else if (script[n].op == OP_DESC) begin
            offer(OP_DESC, desc_word(script[n].ts, script[n].fnum, script[n].kf,
                                     script[n].hlen, script[n].dlen),
                  script[n].typed, script[n].terr);
         end else begin
            offer(OP_BYTE, byte_word(script[n].bval), 1'b0, ERR_NONE);
         end
      end

      // random phases, each under its own payload size; a phase may end
      // mid-frame so the size also changes under a frame in flight
      while (items_sent < ITEM_GOAL) begin
         wait_drained();
         case ($urandom_range(0, 15))
            0:       v = '0;
            1:       v = 11'd1;
            2:       v = '1;
            3:       v = PAYLOAD_LIMIT[PAY_W-1:0];
            4:       v = PAYLOAD_LIMIT[PAY_W-1:0] + 1'b1;
            5:       v = PAYLOAD_LIMIT[PAY_W-1:0] - 1'b1;
            6, 7:    v = PAY_W'($urandom_range(0, 2047));
            default: v = PAY_W'($urandom_range(2, 12));
         endcase
         write_payload_size(v);
         pay = {21'd0, payload_cfg};
         repeat ($urandom_range(4, 12)) begin
            quiet = items_sent >= ITEM_GOAL - QUIET_ITEMS;
            kind  = $urandom_range(0, 99);
            if (kind < 82) begin
               // complete frame, or one cut short by the next descriptor
               if ($urandom_range(0, 19) == 0)
                  total = $urandom_range(1, 300);
               else
                  total = $urandom_range(1, (pay * 4 < 48) ? pay * 4 : 48);
               hlen  = $urandom_range(0, 1) ? 0 : $urandom_range(0, total - 1);
               nsend = (kind < 72) ? total : $urandom_range(0, total - 1);
               offer(OP_DESC, desc_word({$urandom, $urandom}, $urandom, 1'($urandom),
                                        hlen, total - hlen), 1'b0, ERR_NONE);
               repeat (nsend) offer(OP_BYTE, byte_word(8'($urandom)), 1'b0, ERR_NONE);
            end else if (kind < 88) begin
               // error descriptors: empty, random huge lengths, one or two
               // packets past the packet limit
               sub = $urandom_range(0, 2);
               if (sub == 0) begin
                  offer(OP_DESC, desc_word({$urandom, $urandom}, $urandom, 1'($urandom),
                                           $urandom, 32'd0), 1'b0, ERR_NONE);
               end else if (sub == 1) begin
                  offer(OP_DESC, desc_word({$urandom, $urandom}, $urandom, 1'($urandom),
                                           $urandom, $urandom | 32'h8000_0001),
                        1'b0, ERR_NONE);
               end else begin
                  total = 65535 * pay + 1 + $urandom_range(0, pay);
                  hlen  = $urandom_range(0, total - 1);
                  offer(OP_DESC, desc_word({$urandom, $urandom}, $urandom, 1'($urandom),
                                           hlen, total - hlen), 1'b0, ERR_NONE);
               end
            end else if (kind < 94) begin
               // frame of exactly the packet limit, only its head is sent
               total = 65535 * pay - $urandom_range(0, pay - 1);
               hlen  = $urandom_range(0, total - 1);
               offer(OP_DESC, desc_word({$urandom, $urandom}, $urandom, 1'($urandom),
                                        hlen, total - hlen), 1'b0, ERR_NONE);
               repeat ($urandom_range(1, 20))
                  offer(OP_BYTE, byte_word(8'($urandom)), 1'b0, ERR_NONE);
            end else begin
               // loose bytes, ignored unless a frame is still open
               repeat ($urandom_range(1, 3))
                  offer(OP_BYTE, byte_word(8'($urandom)), 1'b0, ERR_NONE);
            end
         end
      end

      wait_drained();
      if (mismatches == 0)
         $display("video_frame_packetizer_test: done, clean");
      else
         $display("video_frame_packetizer_test: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // response side: random back-pressure, plus one long hold-off so the
   // block fills up and stalls its request side
   // ------------------------------------------------------------------------
   initial begin : response_ready
      bit held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && !quiet && items_sent >= 600) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic compare_field(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   // each accepted transaction against the oldest owed tagged byte
   always @(posedge clock) begin : response_check
      pkt_byte_type want;
      rsp_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (tagged_bytes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with nothing owed, byte %0h", $time, got.out_byte);
         end else begin
            want = tagged_bytes_due.pop_front();
            compare_field("out_byte", want.data.out_byte, got.out_byte);
            compare_field("packet_last", want.last, rsp_tlast);
            compare_field("sequence", want.data.sequence_res, got.sequence_res);
            compare_field("packet_index", want.data.packet_index, got.packet_index);
            compare_field("packet_total", want.data.packet_total, got.packet_total);
            compare_field("packet_offset", want.data.packet_offset, got.packet_offset);
            compare_field("frame_length", want.data.frame_length, got.frame_length);
            compare_field("codec_length", want.data.codec_length, got.codec_length);
            compare_field("frame_tag", want.data.frame_tag, got.frame_tag);
            compare_field("frame_time", want.data.frame_time, got.frame_time);
            compare_field("flags", want.flags, rsp_tuser[3:0]);
            compare_field("error", want.err, rsp_tuser[5:4]);
         end
      end
   end

   // hang guard, several times the slowest legal run
   initial begin : watchdog
      #10_000_000;
      $display("video_frame_packetizer_test: done, errors");
      $finish;
   end

endmodule
